// File: rtl/core/sd_spi_init_sequencer_core_assert.svh
// Assertion macros used by the checker of the SD SPI init sequencer.
`ifndef SD_SPI_INIT_SEQUENCER_CORE_ASSERT_SVH
`define SD_SPI_INIT_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SDSPI_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SDSPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/sdspi_pkg.sv
// Types and constants of the SD SPI-mode init sequencer.
package sdspi_pkg;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_CMD0  = 4'd1,
      PH_CMD8  = 4'd2,
      PH_V2_55 = 4'd3,
      PH_V2_41 = 4'd4,
      PH_CMD58 = 4'd5,
      PH_PR_55 = 4'd6,
      PH_PR_41 = 4'd7,
      PH_V1_55 = 4'd8,
      PH_V1_41 = 4'd9,
      PH_MMC   = 4'd10,
      PH_CMD16 = 4'd11
   } phase_type;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DONE  = 1'b1;

   localparam logic [2:0] KIND_UNKNOWN  = 3'd0;
   localparam logic [2:0] KIND_MMC      = 3'd1;
   localparam logic [2:0] KIND_SD_V1    = 3'd2;
   localparam logic [2:0] KIND_SD_V2    = 3'd3;
   localparam logic [2:0] KIND_SD_V2_HC = 3'd4;

   localparam logic [1:0] OUTCOME_OK      = 2'd0;
   localparam logic [1:0] OUTCOME_RESP    = 2'd1;
   localparam logic [1:0] OUTCOME_NO_RESP = 2'd2;

   localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
   localparam logic [5:0] CMD_SEND_OP_MMC  = 6'd1;
   localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
   localparam logic [5:0] CMD_SET_BLOCKLEN = 6'd16;
   localparam logic [5:0] ACMD_SD_SEND_OP  = 6'd41;
   localparam logic [5:0] CMD_APP          = 6'd55;
   localparam logic [5:0] CMD_READ_OCR     = 6'd58;

   localparam logic [31:0] ARG_NONE     = 32'h0000_0000;
   localparam logic [31:0] ARG_IF_COND  = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS      = 32'h4000_0000;
   localparam logic [31:0] ARG_BLOCKLEN = 32'd512;

   localparam logic [7:0] CRC_CMD0  = 8'h95;
   localparam logic [7:0] CRC_CMD8  = 8'h87;
   localparam logic [7:0] CRC_DUMMY = 8'h01;

   localparam logic [7:0]  R1_IDLE    = 8'h01;
   localparam logic [15:0] CHECK_ECHO = 16'h01AA;
   localparam int          OCR_CCS_BIT = 30;

   localparam logic [7:0]  RESET_ATTEMPTS_DEFAULT = 8'd21;
   localparam logic [15:0] READY_ATTEMPTS_DEFAULT = 16'hFFFF;

   localparam logic CSR_RESET_ATTEMPTS = 1'b0;
   localparam logic CSR_READY_ATTEMPTS = 1'b1;

   typedef struct packed {
      logic        op;
      logic        select_failed;
      logic [7:0]  response_byte;
      logic [31:0] trailing_word;
   } req_item_type;

   typedef struct packed {
      logic        issue_command;
      logic [5:0]  command_index;
      logic [31:0] command_argument;
      logic [7:0]  command_crc;
      logic        read_trailing;
      logic        finished;
      logic [2:0]  card_kind;
      logic [1:0]  outcome;
      logic [7:0]  failing_response;
   } rsp_item_type;

   typedef struct packed {
      phase_type   phase;
      logic [15:0] attempts_left;
      logic [2:0]  detected_kind;
      logic [7:0]  last_response;
      logic        last_absent;
   } seq_state_type;

   typedef struct packed {
      logic [7:0]  reset_attempts;
      logic [15:0] ready_attempts;
   } cfg_type;

endpackage

// File: rtl/core/sdspi_req_if.sv
// Request channel interface: command completions and start items.
interface sdspi_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic        select_failed;
   logic [7:0]  response_byte;
   logic [31:0] trailing_word;

   modport source (
      output valid, op, select_failed, response_byte, trailing_word,
      input  ready
   );
   modport sink (
      input  valid, op, select_failed, response_byte, trailing_word,
      output ready
   );
endinterface

// File: rtl/core/sdspi_rsp_if.sv
// Response channel interface: next command or end of initialization.
interface sdspi_rsp_if;
   logic        valid;
   logic        ready;
   logic        issue_command;
   logic [5:0]  command_index;
   logic [31:0] command_argument;
   logic [7:0]  command_crc;
   logic        read_trailing;
   logic        finished;
   logic [2:0]  card_kind;
   logic [1:0]  outcome;
   logic [7:0]  failing_response;

   modport source (
      output valid, issue_command, command_index, command_argument, command_crc,
             read_trailing, finished, card_kind, outcome, failing_response,
      input  ready
   );
   modport sink (
      input  valid, issue_command, command_index, command_argument, command_crc,
             read_trailing, finished, card_kind, outcome, failing_response,
      output ready
   );
endinterface

// File: rtl/core/sdspi_step.sv
// Next-state and result logic of the init sequencer for one item.
module sdspi_step (
   input  sdspi_pkg::seq_state_type cur_state,
   input  sdspi_pkg::req_item_type  item,
   input  sdspi_pkg::cfg_type       cfg,
   output sdspi_pkg::seq_state_type nxt_state,
   output sdspi_pkg::rsp_item_type  result
);

   logic        absent;
   logic        ok0;
   logic        idle_r1;
   logic        spend_ok;
   logic [15:0] spend_val;
   logic [15:0] ready_load;
   logic [15:0] reset_load;
   logic        tracked;
   logic        end_run;
   logic        fail;

   assign absent     = item.select_failed;
   assign ok0        = !absent && (item.response_byte == 8'd0);
   assign idle_r1    = !absent && (item.response_byte == sdspi_pkg::R1_IDLE);
   assign spend_ok   = cur_state.attempts_left > 16'd1;
   assign spend_val  = spend_ok ? (cur_state.attempts_left - 16'd1) : 16'd0;
   assign ready_load = (cfg.ready_attempts == 16'd0) ? 16'd1 : cfg.ready_attempts;
   assign reset_load = (cfg.reset_attempts == 8'd0) ? 16'd1 : {8'd0, cfg.reset_attempts};

   // Only the reset and ready-poll commands feed the failure report.
   always_comb begin
      case (cur_state.phase) inside
         sdspi_pkg::PH_CMD0, sdspi_pkg::PH_V2_41, sdspi_pkg::PH_PR_41,
         sdspi_pkg::PH_V1_41, sdspi_pkg::PH_MMC: tracked = 1'b1;
         default: tracked = 1'b0;
      endcase
   end

   // Next state.
   always_comb begin
      nxt_state = cur_state;
      end_run   = 1'b0;
      fail      = 1'b0;
      if (item.op == sdspi_pkg::OP_START) begin
         nxt_state.phase         = sdspi_pkg::PH_CMD0;
         nxt_state.attempts_left = reset_load;
         nxt_state.detected_kind = sdspi_pkg::KIND_UNKNOWN;
         nxt_state.last_response = 8'd0;
         nxt_state.last_absent   = 1'b0;
      end else begin
         if (tracked) begin
            nxt_state.last_absent   = absent;
            nxt_state.last_response = absent ? 8'd0 : item.response_byte;
         end
         unique case (cur_state.phase)
            sdspi_pkg::PH_CMD0: begin
               if (idle_r1) begin
                  nxt_state.phase = sdspi_pkg::PH_CMD8;
               end else begin
                  nxt_state.attempts_left = spend_val;
                  fail = !spend_ok;
               end
            end
            sdspi_pkg::PH_CMD8: begin
               if (idle_r1) begin
                  if (item.trailing_word[15:0] == sdspi_pkg::CHECK_ECHO) begin
                     nxt_state.attempts_left = ready_load;
                     nxt_state.phase         = sdspi_pkg::PH_V2_55;
                  end else begin
                     fail = 1'b1;
                  end
               end else begin
                  nxt_state.phase = sdspi_pkg::PH_PR_55;
               end
            end
            sdspi_pkg::PH_V2_55: nxt_state.phase = sdspi_pkg::PH_V2_41;
            sdspi_pkg::PH_V2_41: begin
               if (ok0) begin
                  nxt_state.phase = sdspi_pkg::PH_CMD58;
               end else begin
                  nxt_state.attempts_left = spend_val;
                  nxt_state.phase         = sdspi_pkg::PH_V2_55;
                  fail = !spend_ok;
               end
            end
            sdspi_pkg::PH_CMD58: begin
               if (ok0) begin
                  nxt_state.detected_kind = item.trailing_word[sdspi_pkg::OCR_CCS_BIT] ?
                     sdspi_pkg::KIND_SD_V2_HC : sdspi_pkg::KIND_SD_V2;
                  end_run = 1'b1;
               end else begin
                  fail = 1'b1;
               end
            end
            sdspi_pkg::PH_PR_55: nxt_state.phase = sdspi_pkg::PH_PR_41;
            sdspi_pkg::PH_PR_41: begin
               if (absent) begin
                  fail = 1'b1;
               end else if (item.response_byte <= 8'd1) begin
                  nxt_state.detected_kind = sdspi_pkg::KIND_SD_V1;
                  nxt_state.attempts_left = ready_load;
                  nxt_state.phase         = sdspi_pkg::PH_V1_55;
               end else begin
                  nxt_state.detected_kind = sdspi_pkg::KIND_MMC;
                  nxt_state.attempts_left = ready_load;
                  nxt_state.phase         = sdspi_pkg::PH_MMC;
               end
            end
            sdspi_pkg::PH_V1_55: nxt_state.phase = sdspi_pkg::PH_V1_41;
            sdspi_pkg::PH_V1_41: begin
               if (ok0) begin
                  nxt_state.phase = sdspi_pkg::PH_CMD16;
               end else begin
                  nxt_state.attempts_left = spend_val;
                  nxt_state.phase         = sdspi_pkg::PH_V1_55;
                  fail = !spend_ok;
               end
            end
            sdspi_pkg::PH_MMC: begin
               if (ok0) begin
                  nxt_state.phase = sdspi_pkg::PH_CMD16;
               end else begin
                  nxt_state.attempts_left = spend_val;
                  fail = !spend_ok;
               end
            end
            sdspi_pkg::PH_CMD16: begin
               end_run = ok0;
               fail    = !ok0;
            end
            default: begin
               // A completion while idle changes nothing.
            end
         endcase
      end
      if (fail) begin
         nxt_state.detected_kind = sdspi_pkg::KIND_UNKNOWN;
         end_run = 1'b1;
      end
      if (end_run) begin
         nxt_state.phase = sdspi_pkg::PH_IDLE;
      end
   end

   // Result: the command of the phase that follows, or the end report; a completion while idle gives all zeros.
   always_comb begin
      result = '0;
      if (end_run) begin
         result.finished  = 1'b1;
         result.card_kind = nxt_state.detected_kind;
         if (nxt_state.detected_kind != sdspi_pkg::KIND_UNKNOWN) begin
            result.outcome = sdspi_pkg::OUTCOME_OK;
         end else if (!nxt_state.last_absent && (nxt_state.last_response != 8'd0)) begin
            result.outcome          = sdspi_pkg::OUTCOME_RESP;
            result.failing_response = nxt_state.last_response;
         end else begin
            result.outcome = sdspi_pkg::OUTCOME_NO_RESP;
         end
      end else if ((item.op == sdspi_pkg::OP_START) ||
                   (cur_state.phase != sdspi_pkg::PH_IDLE)) begin
         result.issue_command = 1'b1;
         result.command_crc   = sdspi_pkg::CRC_DUMMY;
         unique case (nxt_state.phase) inside
            sdspi_pkg::PH_CMD0: begin
               result.command_index = sdspi_pkg::CMD_GO_IDLE;
               result.command_crc   = sdspi_pkg::CRC_CMD0;
            end
            sdspi_pkg::PH_CMD8: begin
               result.command_index    = sdspi_pkg::CMD_SEND_IF_COND;
               result.command_argument = sdspi_pkg::ARG_IF_COND;
               result.command_crc      = sdspi_pkg::CRC_CMD8;
               result.read_trailing    = 1'b1;
            end
            sdspi_pkg::PH_V2_55, sdspi_pkg::PH_PR_55, sdspi_pkg::PH_V1_55: begin
               result.command_index = sdspi_pkg::CMD_APP;
            end
            sdspi_pkg::PH_V2_41: begin
               result.command_index    = sdspi_pkg::ACMD_SD_SEND_OP;
               result.command_argument = sdspi_pkg::ARG_HCS;
            end
            sdspi_pkg::PH_PR_41, sdspi_pkg::PH_V1_41: begin
               result.command_index = sdspi_pkg::ACMD_SD_SEND_OP;
            end
            sdspi_pkg::PH_CMD58: begin
               result.command_index = sdspi_pkg::CMD_READ_OCR;
               result.read_trailing = 1'b1;
            end
            sdspi_pkg::PH_MMC: begin
               result.command_index = sdspi_pkg::CMD_SEND_OP_MMC;
            end
            sdspi_pkg::PH_CMD16: begin
               result.command_index    = sdspi_pkg::CMD_SET_BLOCKLEN;
               result.command_argument = sdspi_pkg::ARG_BLOCKLEN;
            end
            default: begin
               result = '0;
            end
         endcase
      end
   end

endmodule

// File: rtl/core/sdspi_rsp_stage.sv
// Output register of the response channel.
module sdspi_rsp_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  sdspi_pkg::rsp_item_type in_item,
   output logic                    in_ready,
   output logic                    out_valid,
   output sdspi_pkg::rsp_item_type out_item,
   input  logic                    out_ready
);

   logic                    out_valid_ff;
   logic                    out_valid_in;
   sdspi_pkg::rsp_item_type out_item_ff;

   // The register takes a new item when it is empty or is being emptied.
   assign in_ready     = !out_valid_ff || out_ready;
   assign out_valid_in = in_ready ? in_valid : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         out_item_ff <= in_item;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

// File: rtl/core/sd_spi_init_sequencer_core.sv
// Top level of the SD card SPI-mode initialization sequencer.
//
// The host feeds items on req_chan. An item with op = 0 starts a new run (and
// abandons any run in progress); an item with op = 1 reports how the command
// last issued ended: its R1 byte, a flag for a card that never answered, and
// the four trailing bytes when the command asked for them. Every item yields
// exactly one item on rsp_chan: the next command to send, or the end of the
// run with the card type and outcome. A completion that arrives while no run
// is active yields an all-zero item.
// An accepted item is held in the input register, where the phase logic decides
// the next command and updates the sequencer state; the result is then
// registered in the output register. One item per cycle is sustained while
// rsp_chan does not stall; the limit is the single state update per cycle in
// the phase logic.
// When rsp_chan stalls, the output register holds its item and one more item
// waits in the input register; req_chan.ready then drops until space frees up.
// Reset empties both registers, sets the phase to idle and restores the
// attempt limits to 21 reset attempts and 65535 ready polls. The limits are
// written through csr_* and should only change while the block is idle.
module sd_spi_init_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   sdspi_req_if.sink   req_chan,
   sdspi_rsp_if.source rsp_chan,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   logic                     req_valid_ff;
   logic                     req_valid_in;
   sdspi_pkg::req_item_type  req_item_ff;
   sdspi_pkg::seq_state_type state_ff;
   sdspi_pkg::seq_state_type state_in;
   sdspi_pkg::cfg_type       cfg_ff;
   sdspi_pkg::cfg_type       cfg_in;
   sdspi_pkg::rsp_item_type  step_result;
   sdspi_pkg::rsp_item_type  rsp_item;
   logic                     stage_ready;
   logic                     advance;
   logic                     req_take;

   // The input register moves on whenever the output register can take its result.
   assign advance        = req_valid_ff && stage_ready;
   assign req_chan.ready = !req_valid_ff || stage_ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign req_valid_in   = req_chan.ready ? req_chan.valid : req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_item_ff.op            <= req_chan.op;
         req_item_ff.select_failed <= req_chan.select_failed;
         req_item_ff.response_byte <= req_chan.response_byte;
         req_item_ff.trailing_word <= req_chan.trailing_word;
      end
   end

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            sdspi_pkg::CSR_RESET_ATTEMPTS: cfg_in.reset_attempts = csr_wdata[7:0];
            sdspi_pkg::CSR_READY_ATTEMPTS: cfg_in.ready_attempts = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_attempts <= sdspi_pkg::RESET_ATTEMPTS_DEFAULT;
         cfg_ff.ready_attempts <= sdspi_pkg::READY_ATTEMPTS_DEFAULT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Sequencer state advances once per item, as the item leaves the input register.
   sdspi_step u_step (
      .cur_state (state_ff),
      .item      (req_item_ff),
      .cfg       (cfg_ff),
      .nxt_state (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase         <= sdspi_pkg::PH_IDLE;
         state_ff.attempts_left <= 16'd0;
         state_ff.detected_kind <= sdspi_pkg::KIND_UNKNOWN;
         state_ff.last_response <= 8'd0;
         state_ff.last_absent   <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   sdspi_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid_ff),
      .in_item   (step_result),
      .in_ready  (stage_ready),
      .out_valid (rsp_chan.valid),
      .out_item  (rsp_item),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.issue_command    = rsp_item.issue_command;
   assign rsp_chan.command_index    = rsp_item.command_index;
   assign rsp_chan.command_argument = rsp_item.command_argument;
   assign rsp_chan.command_crc      = rsp_item.command_crc;
   assign rsp_chan.read_trailing    = rsp_item.read_trailing;
   assign rsp_chan.finished         = rsp_item.finished;
   assign rsp_chan.card_kind        = rsp_item.card_kind;
   assign rsp_chan.outcome          = rsp_item.outcome;
   assign rsp_chan.failing_response = rsp_item.failing_response;

endmodule

// File: rtl/core/sdspi_checker.sv
// Port-level checker of the init sequencer, with its bind.
`include "sd_spi_init_sequencer_core_assert.svh"

module sdspi_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        issue_command,
   input logic [5:0]  command_index,
   input logic [31:0] command_argument,
   input logic [7:0]  command_crc,
   input logic        read_trailing,
   input logic        finished,
   input logic [2:0]  card_kind,
   input logic [1:0]  outcome,
   input logic [7:0]  failing_response
);

   logic [61:0] rsp_payload;

   assign rsp_payload = {issue_command, command_index, command_argument, command_crc,
                         read_trailing, finished, card_kind, outcome, failing_response};

   `SDSPI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_payload), "stalled response item changed")
   `SDSPI_ASSERT_IMPLY(a_cmd_or_end, clock, reset, rsp_valid,
      !(issue_command && finished), "item is both a command and an end report")
   `SDSPI_ASSERT_IMPLY(a_cmd_clean, clock, reset, rsp_valid && issue_command,
      (card_kind == sdspi_pkg::KIND_UNKNOWN) && (outcome == sdspi_pkg::OUTCOME_OK) &&
      (failing_response == 8'd0), "command item carries end fields")
   `SDSPI_ASSERT_IMPLY(a_end_clean, clock, reset, rsp_valid && finished,
      (command_index == 6'd0) && (command_argument == 32'd0) && !read_trailing &&
      ((outcome == sdspi_pkg::OUTCOME_OK) != (card_kind == sdspi_pkg::KIND_UNKNOWN)),
      "end item inconsistent")

endmodule

bind sd_spi_init_sequencer_core sdspi_checker u_sdspi_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .issue_command    (rsp_chan.issue_command),
   .command_index    (rsp_chan.command_index),
   .command_argument (rsp_chan.command_argument),
   .command_crc      (rsp_chan.command_crc),
   .read_trailing    (rsp_chan.read_trailing),
   .finished         (rsp_chan.finished),
   .card_kind        (rsp_chan.card_kind),
   .outcome          (rsp_chan.outcome),
   .failing_response (rsp_chan.failing_response)
);
